/* src/sasu_pkg.sv */
// Package for the stable ascending sorter: data width, sequencer states and
// the control bundle that the sequencer drives into the cell row.
// No dependencies.
`default_nettype none
package sasu_pkg;

   localparam int DATA_W = 32;

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic insert;   // place the incoming value into the row
      logic drain;    // shift the row one place towards cell 0
   } cell_ctrl_type;

endpackage
`default_nettype wire

/* src/sasu_cell.sv */
// One cell of the insertion row: holds one stored value and hands it to a
// neighbour when the row opens a gap or drains. Depends on sasu_pkg.
`default_nettype none
module sasu_cell #(
   parameter int INDEX   = 0,
   parameter int COUNT_W = 7
) (
   input  wire                              clock,
   input  sasu_pkg::cell_ctrl_type          ctrl,
   input  wire  [COUNT_W-1:0]               count,
   input  wire  signed [sasu_pkg::DATA_W-1:0] new_value,
   input  wire                              prev_gt,
   input  wire  signed [sasu_pkg::DATA_W-1:0] prev_data,
   input  wire  signed [sasu_pkg::DATA_W-1:0] next_data,
   output logic                             gt,
   output logic signed [sasu_pkg::DATA_W-1:0] data
);

   logic signed [sasu_pkg::DATA_W-1:0] data_ff;
   logic signed [sasu_pkg::DATA_W-1:0] data_in;
   logic                               occupied;

   // An empty cell counts as greater, so the new value lands at the end.
   assign occupied = (COUNT_W'(INDEX) < count);
   assign gt       = !occupied || (data_ff > new_value);
   assign data     = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctrl.insert) begin
         if (prev_gt) begin
            data_in = prev_data;
         end else if (gt) begin
            data_in = new_value;
         end
      end else if (ctrl.drain) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

/* src/sasu_ctrl.sv */
// Sequencer of the sorter: fill count, overflow flag, load/emit state and
// the result strobe. Depends on sasu_pkg.
`default_nettype none
module sasu_ctrl #(
   parameter int CAPACITY = 64,
   parameter int COUNT_W  = 7
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  wire                      last_item,
   output logic                     busy,
   output sasu_pkg::cell_ctrl_type  ctrl,
   output logic [COUNT_W-1:0]       count,
   output logic                     strobe,
   output logic                     last_result,
   output logic                     dropped
);

   sasu_pkg::state_type state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                overflow_ff, overflow_in;
   logic                accept;
   logic                full;

   assign full   = (count_ff == COUNT_W'(CAPACITY));
   assign accept = start && (state_ff == sasu_pkg::ST_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sasu_pkg::ST_LOAD;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      ctrl        = '0;
      strobe      = 1'b0;
      last_result = 1'b0;
      case (state_ff)
         sasu_pkg::ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  overflow_in = 1'b1;   // drop the beat
               end else begin
                  ctrl.insert = 1'b1;
                  count_in    = count_ff + COUNT_W'(1);
               end
               if (last_item) begin
                  state_in = sasu_pkg::ST_EMIT;
               end
            end
         end
         sasu_pkg::ST_EMIT: begin
            strobe      = 1'b1;
            ctrl.drain  = 1'b1;
            last_result = (count_ff == COUNT_W'(1));
            count_in    = count_ff - COUNT_W'(1);
            if (last_result) begin
               state_in    = sasu_pkg::ST_LOAD;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = sasu_pkg::ST_LOAD;
         end
      endcase
   end

   assign busy    = (state_ff == sasu_pkg::ST_EMIT);
   assign count   = count_ff;
   assign dropped = overflow_ff;

endmodule
`default_nettype wire

/* src/stable_ascending_sorter_unit.sv */
// Stable ascending sorter: a row of CAPACITY insertion cells plus a sequencer.
// A beat is accepted while busy is low; each value lands in place in the cell row.
// The closing beat sets busy; results follow from the next cycle, one per
// cycle and one per stored item, read from cell 0 as the row drains.
// Synchronous reset empties the set and returns to loading; cell data is not
// cleared. Results cannot be stalled by the receiver.
`default_nettype none
module stable_ascending_sorter_unit #(
   parameter int CAPACITY = 64
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire  signed [sasu_pkg::DATA_W-1:0]  req_value,
   input  wire                                 req_last_item,
   output logic                                rsp_strobe,
   output logic signed [sasu_pkg::DATA_W-1:0]  rsp_sorted_value,
   output logic                                rsp_last_result,
   output logic                                rsp_dropped
);

   localparam int COUNT_W = $clog2(CAPACITY + 1);

   sasu_pkg::cell_ctrl_type            ctrl;
   logic [COUNT_W-1:0]                 count;
   logic [CAPACITY-1:0]                gt;
   logic signed [sasu_pkg::DATA_W-1:0] data [CAPACITY];

   sasu_ctrl #(
      .CAPACITY (CAPACITY),
      .COUNT_W  (COUNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .last_item   (req_last_item),
      .busy        (busy),
      .ctrl        (ctrl),
      .count       (count),
      .strobe      (rsp_strobe),
      .last_result (rsp_last_result),
      .dropped     (rsp_dropped)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                               prev_gt;
      logic signed [sasu_pkg::DATA_W-1:0] prev_data;
      logic signed [sasu_pkg::DATA_W-1:0] next_data;

      if (i == 0) begin : g_first
         assign prev_gt   = 1'b0;
         assign prev_data = req_value;
      end else begin : g_inner
         assign prev_gt   = gt[i-1];
         assign prev_data = data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_data = data[i];
      end else begin : g_body
         assign next_data = data[i+1];
      end

      sasu_cell #(
         .INDEX   (i),
         .COUNT_W (COUNT_W)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .count     (count),
         .new_value (req_value),
         .prev_gt   (prev_gt),
         .prev_data (prev_data),
         .next_data (next_data),
         .gt        (gt[i]),
         .data      (data[i])
      );
   end

   assign rsp_sorted_value = data[0];

endmodule
`default_nettype wire

/* verif/stable_ascending_sorter_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for stable_ascending_sorter_unit: drives sets of signed values
// and checks each sorted result beat against a scoreboard that keeps its own sorted row.
// Depends on sasu_pkg and the sorter RTL only.

typedef struct {
   logic signed [sasu_pkg::DATA_W-1:0] sorted_value;
   logic                               last_result;
   logic                               dropped;
} sorted_beat_type;

class sort_scoreboard;
   int                                 capacity;
   logic signed [sasu_pkg::DATA_W-1:0] held_row[$];
   logic                               overflow_seen;
   sorted_beat_type                    sorted_q[$];
   int unsigned                        failures;
   int unsigned                        beats_checked;
   int unsigned                        sets_closed;
   int unsigned                        sets_dropped;

   function new(int cap);
      capacity      = cap;
      overflow_seen = 1'b0;
      failures      = 0;
      beats_checked = 0;
      sets_closed   = 0;
      sets_dropped  = 0;
   endfunction

   function int pending();
      return sorted_q.size();
   endfunction

   // Place the value after every held value <= it; close the set on last_item.
   function void note_beat(logic signed [sasu_pkg::DATA_W-1:0] value, logic last_item);
      int              pos;
      sorted_beat_type b;
      if (held_row.size() < capacity) begin
         held_row.push_back(value);
         pos = held_row.size() - 1;
         while (pos > 0 && held_row[pos-1] > value) begin
            held_row[pos] = held_row[pos-1];
            pos--;
         end
         held_row[pos] = value;
      end else begin
         overflow_seen = 1'b1;
      end
      if (last_item) begin
         foreach (held_row[k]) begin
            b.sorted_value = held_row[k];
            b.last_result  = (k == held_row.size() - 1);
            b.dropped      = overflow_seen;
            sorted_q.push_back(b);
         end
         sets_closed++;
         if (overflow_seen)
            sets_dropped++;
         held_row.delete();
         overflow_seen = 1'b0;
      end
   endfunction

   function void check_result(logic signed [sasu_pkg::DATA_W-1:0] value, logic last_result,
                              logic dropped);
      sorted_beat_type b;
      if (sorted_q.size() == 0) begin
         $error("result beat with none expected: sorted_value %0d", value);
         failures++;
         return;
      end
      b = sorted_q.pop_front();
      beats_checked++;
      if (value !== b.sorted_value) begin
         $error("sorted_value: expected %0d, actual %0d", b.sorted_value, value);
         failures++;
      end
      if (last_result !== b.last_result) begin
         $error("last_result: expected %0b, actual %0b", b.last_result, last_result);
         failures++;
      end
      if (dropped !== b.dropped) begin
         $error("dropped: expected %0b, actual %0b", b.dropped, dropped);
         failures++;
      end
   endfunction
endclass

module stable_ascending_sorter_unit_test;

   localparam int CAPACITY     = 64;
   localparam int RANDOM_BEATS = 480;
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic signed [sasu_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [sasu_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic signed [sasu_pkg::DATA_W-1:0] req_value = '0;
   logic                               req_last_item = 1'b0;
   logic                               busy;
   logic                               rsp_strobe;
   logic signed [sasu_pkg::DATA_W-1:0] rsp_sorted_value;
   logic                               rsp_last_result;
   logic                               rsp_dropped;

   sort_scoreboard sb;
   bit             idling = 1'b1;
   int unsigned    beats_sent = 0;
   int unsigned    cycle_count = 0;

   stable_ascending_sorter_unit #(.CAPACITY(CAPACITY)) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .req_last_item   (req_last_item),
      .rsp_strobe      (rsp_strobe),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_last_result (rsp_last_result),
      .rsp_dropped     (rsp_dropped)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("stable_ascending_sorter_unit: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(rsp_sorted_value, rsp_last_result, rsp_dropped);
   end

   // Hold the beat until an edge sees start high with busy low.
   task automatic send_beat(input logic signed [sasu_pkg::DATA_W-1:0] value,
                            input logic last_item);
      while (idling && $urandom_range(99) < 24) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_value     <= value;
      req_last_item <= last_item;
      do @(posedge clock); while (busy);
      sb.note_beat(value, last_item);
      beats_sent++;
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   function automatic logic signed [sasu_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         2, 3:    return $signed($urandom_range(8)) - 4;   // crowd the ties
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_set(input int size);
      for (int i = 0; i < size; i++)
         send_beat(pick_value(), i == size - 1);
   endtask

   initial begin
      int unsigned set_idx;
      int unsigned first_random;
      int          size;
      sb = new(CAPACITY);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-item sets at both extremes
      send_beat(VAL_MAX, 1'b1);
      send_beat(VAL_MIN, 1'b1);
      // mixed signs, extremes and a repeated value
      send_beat(0, 1'b0);
      send_beat(-1, 1'b0);
      send_beat(VAL_MAX, 1'b0);
      send_beat(VAL_MIN, 1'b0);
      send_beat(1, 1'b0);
      send_beat(-1, 1'b1);
      send_beat(3, 1'b0);
      send_beat(3, 1'b0);
      send_beat(-3, 1'b0);
      send_beat(3, 1'b1);
      for (int i = 7; i >= 1; i--)
         send_beat(i, i == 1);
      wait_for_drain();

      first_random = beats_sent;
      set_idx = 0;
      while (beats_sent - first_random < RANDOM_BEATS) begin
         // exactly full, full on the closing beat, then discards before closing
         if (set_idx == 0)
            size = CAPACITY;
         else if (set_idx == 1)
            size = CAPACITY + 1;
         else if (set_idx == 2)
            size = CAPACITY + 6;
         else begin
            case ($urandom_range(99)) inside
               [0:69]:  size = $urandom_range(8, 1);
               [70:84]: size = $urandom_range(40, 9);
               [85:92]: size = $urandom_range(CAPACITY, CAPACITY - 2);
               default: size = $urandom_range(CAPACITY + 6, CAPACITY + 1);
            endcase
         end
         idling = !(set_idx >= 4 && set_idx < 9);
         send_random_set(size);
         if ($urandom_range(9) == 0)
            wait_for_drain();
         set_idx++;
      end

      wait_for_drain();
      repeat (CAPACITY + 8) @(posedge clock);

      $display("%0d beats in %0d sets, %0d sets with discards, %0d sorted beats checked",
               beats_sent, sb.sets_closed, sb.sets_dropped, sb.beats_checked);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("stable_ascending_sorter_unit: match");
      else
         $display("stable_ascending_sorter_unit: mismatch");
      $finish;
   end

endmodule
